@@ sv/dss_pkg.sv @@
// Shared types, constants and segment table for the decimal seven-segment scanner.
package dss_pkg;

    localparam int unsigned DIGIT_COUNT_DEF = 8;
    localparam int unsigned BCD_DIGITS      = 8;
    localparam int unsigned CONV_BITS       = 27;  // 99999999 fits in 27 bits
    localparam int unsigned CNT_W           = $clog2(CONV_BITS + 1);
    localparam logic [31:0] VALUE_LIMIT     = 32'd100000000;
    localparam logic [7:0]  DOT_BIT         = 8'h80;
    localparam logic [3:0]  DOT_NONE        = 4'hF;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [0:0] {
        REQ_SET  = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [31:0]        value;
        logic signed [3:0]  point_pos;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [2:0] digit_select;
        logic [7:0] segment_pattern;
        logic       latch_on;
    } t_result;

    // Segments G..A in bits 6..0; B and D carry the dot to set them apart from 8 and 0.
    function automatic logic [7:0] seg_lookup(input logic [3:0] nib);
        logic [7:0] pat;
        unique case (nib)
            4'h0: pat = 8'h3F;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5B;
            4'h3: pat = 8'h4F;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6D;
            4'h6: pat = 8'h7D;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7F;
            4'h9: pat = 8'h6F;
            4'hA: pat = 8'h77;
            4'hB: pat = 8'hFF;
            4'hC: pat = 8'h39;
            4'hD: pat = 8'hBF;
            4'hE: pat = 8'h79;
            4'hF: pat = 8'h71;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ sv/dss_bcd_cell.sv @@
// One BCD digit cell of the shift-and-add-3 converter chain.
module dss_bcd_cell
    import dss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_shift,
    input  logic       i_carry,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = 4'd0;
        end else if (i_shift) begin
            n_digit = {w_adj[2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 4'd0;
        end else begin
            r_digit <= n_digit;
        end
    end

endmodule

@@ sv/decimal_seven_segment_scanner.sv @@
// Top level: eight-digit multiplexed seven-segment driver with binary to BCD conversion.
//
// Usage
//   Command channel: an item is taken on a clock edge with start high and busy
//   low. req_type selects a set (value plus dot position) or a scan tick.
//   Result channel: every item yields one beat, shown on o_result for exactly
//   one cycle with o_strobe high. The receiver cannot stall; it must take it.
//   Config: APB-style port, display_enable at byte address 0, pready tied high.
// Timing
//   Tick: result beat in the cycle after acceptance; a tick can be taken every
//   cycle while no conversion is in flight. Out-of-range set (value >=
//   100000000): result next cycle, no state change. Valid set: busy stays high
//   while a row of eight BCD digit cells shifts the value in MSB first (one bit
//   per cycle, add-3 per cell); the result beat comes as busy falls, and no new
//   item is taken before then, so sets are bound by the bit-serial shift.
// Reset
//   Synchronous, active low: digits cleared to zero, no dot, scan index 0,
//   display enabled, no conversion in flight and no pending beat.
// Display
//   Ticks while enabled drive the current digit and advance the scan modulo
//   DIGIT_COUNT; while disabled they only report the latch off.
module decimal_seven_segment_scanner
    import dss_pkg::*;
#(
    parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel
    output logic        o_strobe,
    output t_result     o_result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] LAST_DIGIT = 3'(DIGIT_COUNT - 1);

    // control state
    logic             r_en;
    logic [CNT_W-1:0] r_cnt;
    logic             r_strobe;
    logic [2:0]       r_scan;
    logic [3:0]       r_dot;
    // payload
    logic [CONV_BITS-1:0] r_bin;
    t_result              r_result;

    logic    n_strobe;
    t_result n_result;
    logic    w_accept;
    logic    w_cfg_wr;
    logic    w_in_range;
    logic    w_load;

    // digit cell chain; the last carry is the overflow out of the top digit
    logic [3:0] w_digit [BCD_DIGITS];
    logic       w_carry [BCD_DIGITS+1];
    logic [3:0] w_nib;
    logic [7:0] w_pat;

    assign busy       = (r_cnt != '0);
    assign w_accept   = start && !busy;
    assign w_in_range = (i_req.value < VALUE_LIMIT);
    assign w_load     = w_accept && (i_req.req_type == REQ_SET) && w_in_range;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_en} : 32'd0;

    // cell 0 takes the next binary bit; each cell hands its carry upward
    assign w_carry[0] = r_bin[CONV_BITS-1];

    for (genvar k = 0; k < BCD_DIGITS; k++) begin : g_cell
        dss_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_load),
            .i_shift (busy),
            .i_carry (w_carry[k]),
            .o_carry (w_carry[k+1]),
            .o_digit (w_digit[k])
        );
    end

    // segment pattern of the digit under the scan pointer
    assign w_nib = w_digit[r_scan];
    always_comb begin
        w_pat = seg_lookup(w_nib);
        // negative dot codes have bit 3 set and never match
        if (!r_dot[3] && (r_dot[2:0] == r_scan)) begin
            w_pat = w_pat | DOT_BIT;
        end
    end

    always_comb begin
        n_strobe = 1'b0;
        n_result = '0;
        if (w_accept) begin
            n_strobe = (i_req.req_type == REQ_TICK) || !w_in_range;
            if (i_req.req_type == REQ_TICK) begin
                if (r_en) begin
                    n_result.digit_select    = r_scan;
                    n_result.segment_pattern = w_pat;
                    n_result.latch_on        = 1'b1;
                end
            end else begin
                n_result.status = w_in_range ? STATUS_OK : STATUS_RANGE;
            end
        end else if (r_cnt == CNT_W'(1)) begin
            // last shift of a conversion
            n_strobe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b1;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_scan   <= 3'd0;
            r_dot    <= DOT_NONE;
        end else begin
            r_strobe <= n_strobe;
            if (w_cfg_wr && (paddr[2] == 1'b0)) begin
                r_en <= pwdata[0];
            end
            if (w_load) begin
                r_cnt <= CNT_W'(CONV_BITS);
                r_dot <= i_req.point_pos;
            end else if (busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w_accept && (i_req.req_type == REQ_TICK) && r_en) begin
                r_scan <= (r_scan == LAST_DIGIT) ? 3'd0 : r_scan + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_load) begin
            r_bin <= i_req.value[CONV_BITS-1:0];
        end else if (busy) begin
            r_bin <= {r_bin[CONV_BITS-2:0], 1'b0};
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // end of a conversion always delivers its beat
    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("conversion finished without a result beat");

    // a tick always yields a beat on the next cycle
    a_tick_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_TICK) |=> o_strobe)
        else $error("tick without result beat");

    // blanked beats carry no segments
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.latch_on) |-> (o_result.segment_pattern == 8'd0))
        else $error("segments driven while latch off");

    // no new beat may appear in the middle of a conversion
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_strobe)
        else $error("result beat during conversion");

    // in-range values never carry out of the top digit while shifting
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_carry[BCD_DIGITS])
        else $error("BCD row overflow");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the decimal seven-segment scanner: set/tick traffic, display enable.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    // Segment glyphs, bit7 dot, bits6..0 G..A. B and D carry the dot on their own.
    localparam logic [7:0] GLYPHS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'hFF, 8'h39, 8'hBF, 8'h79, 8'h71
    };
    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;  // no register behind it, writes dropped
    localparam int PHASE_ITEMS = 300;
    localparam int PHASES      = 6;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    decimal_seven_segment_scanner i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the display state, advanced once per accepted command beat.
    logic [31:0] shown_bcd    = '0;
    logic [7:0]  shown_dot    = 8'hFF;   // sign-extended dot digit, 0xFF = no dot
    logic [2:0]  scan_pos     = '0;
    logic        shown_enable = 1'b1;

    t_req    cmd_backlog [$];   // commands waiting for the driver
    t_result owed_beats  [$];   // result beats the block still owes, oldest first

    int  err_count   = 0;
    int  n_sets      = 0;
    int  n_rejects   = 0;
    int  n_ticks     = 0;
    int  n_dark      = 0;
    int  n_writes    = 0;
    bit  sender_idles = 1'b1;
    int  gap_left    = 0;
    int  calm_left   = 0;

    // Eight packed BCD digits, digit 0 in bits 3..0.
    function automatic logic [31:0] decimal_nibbles(input logic [31:0] bin);
        logic [31:0] packed_digits;
        int unsigned rest;
        packed_digits = '0;
        rest = bin;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            packed_digits[4*d +: 4] = 4'(rest % 10);
            rest = rest / 10;
        end
        return packed_digits;
    endfunction

    // Apply one command to the shadow state and queue the beat it must produce.
    task automatic advance_display(input t_req cmd);
        t_result    beat;
        logic [7:0] glyph;
        beat = '0;
        if (cmd.req_type == REQ_SET) begin
            n_sets++;
            if (cmd.value >= VALUE_LIMIT) begin
                // out of range: flagged, state untouched
                beat.status = STATUS_RANGE;
                n_rejects++;
            end else begin
                shown_bcd = decimal_nibbles(cmd.value);
                shown_dot = {{4{cmd.point_pos[3]}}, cmd.point_pos};
            end
        end else begin
            n_ticks++;
            if (shown_enable) begin
                glyph = GLYPHS[shown_bcd[4*scan_pos +: 4]];
                // negative or >7 dot positions never light the dot
                if (shown_dot < 8'd8 && shown_dot[2:0] == scan_pos)
                    glyph = glyph | DOT_BIT;
                beat.digit_select    = scan_pos;
                beat.segment_pattern = glyph;
                beat.latch_on        = 1'b1;
                scan_pos = (scan_pos == 3'(DIGIT_COUNT_DEF - 1)) ? 3'd0 : scan_pos + 3'd1;
            end else begin
                // blanked: all-zero beat, scan does not move
                n_dark++;
            end
        end
        owed_beats.push_back(beat);
    endtask

    function automatic t_req mk_cmd(input t_req_type kind, input logic [31:0] val,
                                    input logic signed [3:0] dot);
        t_req c;
        c.req_type  = kind;
        c.value     = val;
        c.point_pos = dot;
        return c;
    endfunction

    // Random command: mostly ticks and in-range sets, some out-of-range noise.
    // Tick payload fields are random too, so ignored bits still toggle.
    function automatic t_req random_command();
        int          pick;
        logic [31:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            return mk_cmd(REQ_TICK, $urandom, 4'($urandom));
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0:       val = $urandom_range(0, 999);
                1:       val = VALUE_LIMIT - 1 - $urandom_range(0, 3);
                default: val = $urandom_range(0, VALUE_LIMIT - 1);
            endcase
            return mk_cmd(REQ_SET, val, 4'($urandom));
        end else begin
            // reject path; the upper value bits move here and in tick payloads
            if ($urandom_range(0, 3) == 0)
                val = VALUE_LIMIT + $urandom_range(0, 3);
            else
                val = $urandom_range(VALUE_LIMIT, 32'hFFFF_FFFF);
            return mk_cmd(REQ_SET, val, 4'($urandom));
        end
    endfunction

    // Command driver. A beat goes in on an edge with start high and busy low;
    // start stays up while busy holds it off. Gaps are thrown in at random
    // between beats, with occasional calm stretches that have none.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_left  <= 0;
            calm_left <= 0;
        end else begin
            if (start && !busy)
                advance_display(i_req);
            if (start && busy) begin
                // held off: keep the same beat on the bus
            end else if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_backlog.size() == 0) begin
                start <= 1'b0;
            end else if (sender_idles && calm_left == 0 && $urandom_range(0, 3) == 0) begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 10);
            end else begin
                i_req <= cmd_backlog.pop_front();
                start <= 1'b1;
                if (calm_left != 0)
                    calm_left <= calm_left - 1;
                else if ($urandom_range(0, 31) == 0)
                    calm_left <= $urandom_range(20, 60);
            end
        end
    end

    // Result monitor: every strobe is one beat, matched against the oldest owed one.
    always @(posedge i_clk) begin : watch_beats
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, o_result);
                err_count++;
            end else begin
                want = owed_beats.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d",
                             $time, want.status, o_result.status);
                    err_count++;
                end
                if (o_result.digit_select !== want.digit_select) begin
                    $display("%0t: digit_select exp %0d got %0d",
                             $time, want.digit_select, o_result.digit_select);
                    err_count++;
                end
                if (o_result.segment_pattern !== want.segment_pattern) begin
                    $display("%0t: segment_pattern exp %02h got %02h",
                             $time, want.segment_pattern, o_result.segment_pattern);
                    err_count++;
                end
                if (o_result.latch_on !== want.latch_on) begin
                    $display("%0t: latch_on exp %0d got %0d",
                             $time, want.latch_on, o_result.latch_on);
                    err_count++;
                end
            end
        end
    end

    // Block idle: every command taken, nothing busy, nothing owed.
    task automatic settle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || busy || owed_beats.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write: setup then access, committed on the access edge with pready high.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] wdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENABLE)
            shown_enable = wdata[0];
        n_writes++;
    endtask

    // APB read of the enable register, checked against the shadow.
    task automatic enable_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ENABLE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'b0, shown_enable}) begin
            $display("%0t: display_enable readback exp %0d got %08h",
                     $time, shown_enable, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        logic en;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset glyph, both value extremes, both reject flavors,
        // every dot position class, full scan wrap over 99999999.
        cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, DOT_NONE));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'hFFFF_FFFF, 4'sd7));
        cmd_backlog.push_back(mk_cmd(REQ_SET, VALUE_LIMIT - 1, 4'sd7));
        repeat (8) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_SET, VALUE_LIMIT, 4'sd2));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'hFFFF_FFFF, 4'sh8));
        cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'd12345678, DOT_NONE));
        repeat (3) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'd90817263, 4'shD));
        repeat (2) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'd5, 4'sd4));
        settle();
        enable_readback();

        // Blanked display: ticks report latch off, sets still land.
        reg_write(ADDR_ENABLE, 32'd0);
        enable_readback();
        repeat (2) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        cmd_backlog.push_back(mk_cmd(REQ_SET, 32'd4321, 4'sd1));
        repeat (2) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        settle();

        // Write to the empty slot must not re-enable.
        reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        enable_readback();
        cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        settle();

        // Only bit 0 counts; scan resumes where it stopped.
        reg_write(ADDR_ENABLE, 32'hFFFF_FFFF);
        enable_readback();
        repeat (3) cmd_backlog.push_back(mk_cmd(REQ_TICK, 32'd0, 4'sd0));
        settle();

        // Random phases; enable varies per phase, final one enabled and gap-free.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 2, PHASES - 1: en = 1'b1;
                1:                en = 1'b0;
                default:          en = 1'($urandom);
            endcase
            reg_write(ADDR_ENABLE, {31'($urandom), en});
            sender_idles = (p != PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
                cmd_backlog.push_back(random_command());
            settle();
        end

        // Drain with a bound; anything still owed is a miss.
        for (int w = 0; w < 200 && owed_beats.size() != 0; w++)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (owed_beats.size() != 0) begin
            $display("%0t: %0d beats never arrived", $time, owed_beats.size());
            err_count += owed_beats.size();
        end

        $display("covered %0d sets (%0d rejected) and %0d ticks (%0d blanked)",
                 n_sets, n_rejects, n_ticks, n_dark);
        $display("over %0d register writes, %0d mismatches", n_writes, err_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ decimal_seven_segment_scanner.f @@
sv/dss_pkg.sv
sv/dss_bcd_cell.sv
sv/decimal_seven_segment_scanner.sv
bench/tb.sv
